>>> design/cbf_pkg.sv
// Shared types, constants and blending weights for the cubic Bezier flattener.
package cbf_pkg;

    localparam int STEPS        = 8;
    localparam int STEP_BITS    = 3;
    localparam int WEIGHT_BITS  = 10;
    localparam int NUM_POINTS   = 4;
    localparam int ROUND_SHIFT  = 9;
    localparam int CORNER_STEPS = 2;

    localparam logic [STEP_BITS-1:0] LAST_CURVE_STEP  = STEP_BITS'(STEPS - 1);
    localparam logic [STEP_BITS-1:0] LAST_CORNER_STEP = STEP_BITS'(CORNER_STEPS - 1);

    // Point slots: blend start, first control, second control, end.
    localparam int PT_START = 0;
    localparam int PT_C0    = 1;
    localparam int PT_C1    = 2;
    localparam int PT_END   = 3;

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef weight_t weight_set_t [NUM_POINTS];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 issue;
        logic                 advance;
        logic                 corner;
        logic [STEP_BITS-1:0] step;
    } cbf_cmd_t;

    // Weights for one vertex; they always sum to 512.
    // A corner picks the second control point, then the end point, exactly.
    function automatic weight_set_t get_weights(input logic corner,
                                                input logic [STEP_BITS-1:0] step);
        weight_set_t w;
        w[PT_START] = '0;
        w[PT_C0]    = '0;
        w[PT_C1]    = '0;
        w[PT_END]   = '0;
        if (corner) begin
            if (step == '0) begin
                w[PT_C1] = 10'd512;
            end else begin
                w[PT_END] = 10'd512;
            end
        end else begin
            case (step)
                3'd0:
                begin
                    w[PT_START] = 10'd343; w[PT_C0] = 10'd147;
                    w[PT_C1]    = 10'd21;  w[PT_END] = 10'd1;
                end
                3'd1:
                begin
                    w[PT_START] = 10'd216; w[PT_C0] = 10'd216;
                    w[PT_C1]    = 10'd72;  w[PT_END] = 10'd8;
                end
                3'd2:
                begin
                    w[PT_START] = 10'd125; w[PT_C0] = 10'd225;
                    w[PT_C1]    = 10'd135; w[PT_END] = 10'd27;
                end
                3'd3:
                begin
                    w[PT_START] = 10'd64;  w[PT_C0] = 10'd192;
                    w[PT_C1]    = 10'd192; w[PT_END] = 10'd64;
                end
                3'd4:
                begin
                    w[PT_START] = 10'd27;  w[PT_C0] = 10'd135;
                    w[PT_C1]    = 10'd225; w[PT_END] = 10'd125;
                end
                3'd5:
                begin
                    w[PT_START] = 10'd8;   w[PT_C0] = 10'd72;
                    w[PT_C1]    = 10'd216; w[PT_END] = 10'd216;
                end
                3'd6:
                begin
                    w[PT_START] = 10'd1;   w[PT_C0] = 10'd21;
                    w[PT_C1]    = 10'd147; w[PT_END] = 10'd343;
                end
                default:
                begin
                    w[PT_END] = 10'd512;
                end
            endcase
        end
        return w;
    endfunction

endpackage

>>> design/cubic_bezier_flattener_unit.sv
// Top level of the cubic Bezier flattener: stream ports, controller and datapath.
// After its input beat, the first vertex of a segment passes the point, product and vertex registers in turn.
// Sequencing: a curve segment is one accept and eight vertex issues, a corner segment one
// accept and two vertex issues; the shared multiply and round pipeline issues one vertex
// per cycle and stalls as a whole when the output beat is not taken.
// Reset: rst_n clears the controller and the stored previous end point to the origin.
module cubic_bezier_flattener_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    // Input segment stream.
    input  logic s_tvalid,
    output logic s_tready,
    // tdata, lowest bit up: ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, end_x, end_y, zero fill.
    input  logic [((6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser, lowest bit up: is_corner, first_segment.
    input  logic [1:0] s_tuser,
    // Output vertex stream.
    output logic m_tvalid,
    input  logic m_tready,
    // tdata, lowest bit up: vertex_x, vertex_y, zero fill.
    output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // tlast marks the final vertex of a segment (last_of_run).
    output logic m_tlast
);
    import cbf_pkg::*;

    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

    cbf_cmd_t cmd;
    logic signed [COORD_BITS-1:0] vertex_x, vertex_y;

    // The controller owns both handshakes and the per-vertex step counter.
    cbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_corner (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cmd       (cmd)
    );

    // The datapath latches the segment on the accepted beat and blends one vertex
    // per issued step: weighted products in one stage, sum and round in the next.
    cbf_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .first_segment (s_tuser[1]),
        .ctrl0_x       (s_tdata[0 * COORD_BITS +: COORD_BITS]),
        .ctrl0_y       (s_tdata[1 * COORD_BITS +: COORD_BITS]),
        .ctrl1_x       (s_tdata[2 * COORD_BITS +: COORD_BITS]),
        .ctrl1_y       (s_tdata[3 * COORD_BITS +: COORD_BITS]),
        .end_x         (s_tdata[4 * COORD_BITS +: COORD_BITS]),
        .end_y         (s_tdata[5 * COORD_BITS +: COORD_BITS]),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y)
    );

    assign m_tdata = OUT_W'({vertex_y, vertex_x});

endmodule

>>> design/cbf_ctrl.sv
// Controller: segment handshake, vertex step sequencing and pipeline valid tracking.
module cbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_corner,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output cbf_pkg::cbf_cmd_t cmd
);
    import cbf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 corner_reg, corner_next;
    logic                 p_valid_reg, p_valid_next;
    logic                 p_last_reg, p_last_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_last_reg, out_last_next;

    logic accept;
    logic advance;
    logic issue;
    logic last_step;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_RUN) && advance;
    assign last_step = corner_reg ? (step_reg == LAST_CORNER_STEP)
                                  : (step_reg == LAST_CURVE_STEP);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next  = ST_RUN;
                    step_next   = '0;
                    corner_next = in_corner;
                end
            end
            ST_RUN:
            begin
                if (issue) begin
                    step_next = step_reg + 1'b1;
                    if (last_step) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        p_valid_next   = p_valid_reg;
        p_last_next    = p_last_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            p_valid_next   = issue;
            p_last_next    = issue && last_step;
            out_valid_next = p_valid_reg;
            out_last_next  = p_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            corner_reg    <= 1'b0;
            p_valid_reg   <= 1'b0;
            p_last_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            corner_reg    <= corner_next;
            p_valid_reg   <= p_valid_next;
            p_last_reg    <= p_last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_tlast     = out_last_reg;
    assign cmd.load    = accept;
    assign cmd.issue   = issue;
    assign cmd.advance = advance;
    assign cmd.corner  = corner_reg;
    assign cmd.step    = step_reg;

endmodule

>>> design/cbf_datapath.sv
// Datapath: point registers, previous end point, weighted products and rounded sum.
module cbf_datapath #(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbf_pkg::cbf_cmd_t            cmd,
    input  logic                         first_segment,
    input  logic signed [COORD_BITS-1:0] ctrl0_x,
    input  logic signed [COORD_BITS-1:0] ctrl0_y,
    input  logic signed [COORD_BITS-1:0] ctrl1_x,
    input  logic signed [COORD_BITS-1:0] ctrl1_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y
);
    import cbf_pkg::*;

    localparam int PROD_W = COORD_BITS + WEIGHT_BITS + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (ROUND_SHIFT - 1));

    logic signed [COORD_BITS-1:0] pt_x_reg [NUM_POINTS];
    logic signed [COORD_BITS-1:0] pt_y_reg [NUM_POINTS];
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [PROD_W-1:0]     prod_x_reg [NUM_POINTS];
    logic signed [PROD_W-1:0]     prod_y_reg [NUM_POINTS];
    logic signed [PROD_W-1:0]     prod_x_next [NUM_POINTS];
    logic signed [PROD_W-1:0]     prod_y_next [NUM_POINTS];
    logic signed [COORD_BITS-1:0] vx_reg, vy_reg;

    weight_set_t              w;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [SUM_W-1:0]  rnd_x, rnd_y;

    assign w = get_weights(cmd.corner, cmd.step);

    always_comb
    begin
        logic signed [PROD_W-1:0] wx;
        for (int i = 0; i < NUM_POINTS; i++) begin
            wx             = PROD_W'({1'b0, w[i]});
            prod_x_next[i] = PROD_W'(pt_x_reg[i]) * wx;
            prod_y_next[i] = PROD_W'(pt_y_reg[i]) * wx;
        end
    end

    always_comb
    begin
        sum_x = ROUND_HALF;
        sum_y = ROUND_HALF;
        for (int i = 0; i < NUM_POINTS; i++) begin
            sum_x = sum_x + SUM_W'(prod_x_reg[i]);
            sum_y = sum_y + SUM_W'(prod_y_reg[i]);
        end
        rnd_x = sum_x >>> ROUND_SHIFT;
        rnd_y = sum_y >>> ROUND_SHIFT;
    end

    // The previous end point is real state and resets to the origin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else if (cmd.load) begin
            prev_x_reg <= end_x;
            prev_y_reg <= end_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            pt_x_reg[PT_START] <= first_segment ? ctrl0_x : prev_x_reg;
            pt_y_reg[PT_START] <= first_segment ? ctrl0_y : prev_y_reg;
            pt_x_reg[PT_C0]    <= ctrl0_x;
            pt_y_reg[PT_C0]    <= ctrl0_y;
            pt_x_reg[PT_C1]    <= ctrl1_x;
            pt_y_reg[PT_C1]    <= ctrl1_y;
            pt_x_reg[PT_END]   <= end_x;
            pt_y_reg[PT_END]   <= end_y;
        end
        if (cmd.issue) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (cmd.advance) begin
            vx_reg <= rnd_x[COORD_BITS-1:0];
            vy_reg <= rnd_y[COORD_BITS-1:0];
        end
    end

    assign vertex_x = vx_reg;
    assign vertex_y = vy_reg;

endmodule
